[rtl/pcfl_pkg.sv]
// ----------------------------------------------------------------------------
// pcfl_pkg
// Types and fixed constants shared by the page-carved free list allocator.
// ----------------------------------------------------------------------------
package pcfl_pkg;

  localparam int ADDR_W     = 16;
  localparam int SPAN_W     = ADDR_W + 1;
  localparam int LINK_DEPTH = 8192;
  localparam int LINK_AW    = 13;
  localparam int SLOT_W     = 9;
  localparam int SIZE_W     = SLOT_W + 3;

  localparam logic [SLOT_W-1:0] SLOT_WORDS_RESET = 9'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOM = 1'b1;

  typedef struct packed {
    logic capture;
    logic free;
    logic pop;
    logic carve_start;
    logic carve_step;
    logic fail;
    logic load_out;
  } pcfl_cmd_t;

  typedef struct packed {
    logic op_free;
    logic head_empty;
    logic carve_ok;
    logic carve_last;
  } pcfl_stat_t;

endpackage

[rtl/pcfl_req_if.sv]
// ----------------------------------------------------------------------------
// pcfl_req_if
// Request channel: opcode and address with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcfl_req_if;
  import pcfl_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

[rtl/pcfl_rsp_if.sv]
// ----------------------------------------------------------------------------
// pcfl_rsp_if
// Response channel: slot address and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcfl_rsp_if;
  import pcfl_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] slot_address;
  logic              status;

  modport source (output valid, output slot_address, output status, input ready);
  modport sink   (input valid, input slot_address, input status, output ready);
endinterface

[rtl/pcfl_datapath.sv]
// ----------------------------------------------------------------------------
// pcfl_datapath
// Link memory, list head, page cursor, carving cursor and result registers.
// ----------------------------------------------------------------------------
module pcfl_datapath #(
  parameter int PAGE_BYTES = 4096,
  parameter int POOL_PAGES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pcfl_pkg::SLOT_W-1:0] cfg_wdata,
  input  logic                        in_opcode,
  input  logic [pcfl_pkg::ADDR_W-1:0] in_address,
  input  pcfl_pkg::pcfl_cmd_t         cmd,
  output pcfl_pkg::pcfl_stat_t        stat,
  output logic [pcfl_pkg::ADDR_W-1:0] slot_address,
  output logic                        status
);
  import pcfl_pkg::*;

  localparam int PG_W = $clog2(POOL_PAGES + 1);
  localparam logic [SPAN_W-1:0] PAGE_SZ    = SPAN_W'(PAGE_BYTES);
  localparam logic [SPAN_W-1:0] ADDR_SPAN  = {1'b1, {ADDR_W{1'b0}}};
  localparam logic [PG_W-1:0]   PAGES_MAX  = PG_W'(POOL_PAGES);

  logic [ADDR_W-1:0] link_mem [LINK_DEPTH];
  logic [ADDR_W-1:0] link_rdata;

  logic [SLOT_W-1:0] slot_words;
  logic [ADDR_W-1:0] head;
  logic [PG_W-1:0]   pages;
  logic [SPAN_W-1:0] base;
  logic [SPAN_W-1:0] cur;
  logic [SPAN_W-1:0] end_addr;
  logic              first;
  logic              op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] res_addr;
  logic              res_status;

  logic [SLOT_W-1:0] words;
  logic [SPAN_W-1:0] size;
  logic [SPAN_W-1:0] size2;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] limit;
  logic [SPAN_W-1:0] first_slot;
  logic [SPAN_W-1:0] nxt;
  logic [SPAN_W:0]   nxt2;
  logic              last;
  logic              pool_left;
  logic              push_we;
  logic              mem_we;
  logic [LINK_AW-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] carve_link;

  // zero slot size behaves as one word
  assign words      = (slot_words == '0) ? SLOT_W'(1) : slot_words;
  assign size       = SPAN_W'({words, 3'b000});
  assign size2      = SPAN_W'({words, 4'b0000});
  assign span       = ADDR_SPAN - base;
  assign limit      = (PAGE_SZ < span) ? PAGE_SZ : span;
  assign first_slot = base + size;
  assign pool_left  = (pages < PAGES_MAX) && !base[ADDR_W];

  assign nxt        = cur + size;
  assign nxt2       = {1'b0, cur} + {1'b0, size2};
  assign last       = nxt2 > {1'b0, end_addr};
  assign carve_link = last ? '0 : nxt[ADDR_W-1:0];

  assign push_we   = cmd.free && (addr_q != '0);
  assign mem_we    = push_we || cmd.carve_step;
  assign mem_waddr = cmd.carve_step ? cur[ADDR_W-1:3] : addr_q[ADDR_W-1:3];
  assign mem_wdata = cmd.carve_step ? carve_link : head;

  assign stat.op_free    = (op_q == OP_FREE);
  assign stat.head_empty = (head == '0);
  assign stat.carve_ok   = pool_left && (size2 <= limit);
  assign stat.carve_last = last;

  // link memory: one write port, read port follows the list head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    link_rdata <= link_mem[head[ADDR_W-1:3]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_words <= SLOT_WORDS_RESET;
      head       <= '0;
      pages      <= '0;
      base       <= '0;
    end else begin
      if (cfg_we) begin
        slot_words <= cfg_wdata;
      end
      if (push_we) begin
        head <= addr_q;
      end else if (cmd.pop) begin
        head <= link_rdata;
      end else if (cmd.carve_step && first) begin
        head <= carve_link;
      end
      if (cmd.carve_step && last) begin
        pages <= pages + PG_W'(1);
        base  <= base + PAGE_SZ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= in_opcode;
      addr_q <= in_address;
    end
    if (cmd.carve_start) begin
      cur      <= first_slot;
      end_addr <= base + limit;
      first    <= 1'b1;
    end else if (cmd.carve_step) begin
      cur   <= nxt;
      first <= 1'b0;
    end
    if (cmd.free) begin
      res_addr   <= '0;
      res_status <= STATUS_OK;
    end else if (cmd.pop) begin
      res_addr   <= head;
      res_status <= STATUS_OK;
    end else if (cmd.carve_start) begin
      res_addr   <= first_slot[ADDR_W-1:0];
      res_status <= STATUS_OK;
    end else if (cmd.fail) begin
      res_addr   <= '0;
      res_status <= STATUS_OOM;
    end
    if (cmd.load_out) begin
      slot_address <= res_addr;
      status       <= res_status;
    end
  end

endmodule

[rtl/pcfl_ctrl.sv]
// ----------------------------------------------------------------------------
// pcfl_ctrl
// Sequencer: accepts a word, issues pop, push, page carving or an out-of-memory
// result, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pcfl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pcfl_pkg::pcfl_stat_t stat,
  output pcfl_pkg::pcfl_cmd_t  cmd
);
  import pcfl_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_CARVE  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) || ((state == S_FINISH) && out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op_free) begin
          cmd.free   = 1'b1;
          state_next = S_FINISH;
        end else if (!stat.head_empty) begin
          cmd.pop    = 1'b1;
          state_next = S_FINISH;
        end else if (stat.carve_ok) begin
          cmd.carve_start = 1'b1;
          state_next      = S_CARVE;
        end else begin
          cmd.fail   = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_CARVE: begin
        cmd.carve_step = 1'b1;
        if (stat.carve_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = accept ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.free, cmd.pop, cmd.carve_start, cmd.fail, cmd.carve_step}))
    else $error("more than one datapath action in a cycle");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted word did not enter execute");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten while held");

  a_carve_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.carve_start |=> cmd.carve_step)
    else $error("carving start not followed by a carve step");

endmodule

[rtl/page_carved_free_list_allocator_unit.sv]
// An allocate or free word goes from acceptance through execute, then
// hand-off, to its result in the output register; a new word is taken in
// the hand-off cycle when the output register is free. An allocate that
// finds the free list empty carves the next page, writing one link per slot
// into the link memory through its one write port, for each whole slot that
// fits in the page after its header. The link memory needs no clearing pass
// after reset. A free is pushed unchecked; address 0 is ignored. The user
// must write slot_words only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
// page_carved_free_list_allocator_unit
// Fixed-size slot allocator over a pool of pages with a LIFO free list.
// ----------------------------------------------------------------------------
module page_carved_free_list_allocator_unit #(
  parameter int PAGE_BYTES = 4096,
  parameter int POOL_PAGES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pcfl_pkg::SLOT_W-1:0] cfg_wdata,
  pcfl_req_if.sink                    req,
  pcfl_rsp_if.source                  rsp
);
  import pcfl_pkg::*;

  pcfl_cmd_t  cmd;
  pcfl_stat_t stat;

  pcfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcfl_datapath #(
    .PAGE_BYTES (PAGE_BYTES),
    .POOL_PAGES (POOL_PAGES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_opcode    (req.opcode),
    .in_address   (req.address),
    .cmd          (cmd),
    .stat         (stat),
    .slot_address (rsp.slot_address),
    .status       (rsp.status)
  );

endmodule
